// ===== rtl/small_prng_bounded_int_assert.svh =====
// Assertion macros shared by the generator block, compiled out for synthesis.
`ifndef SMALL_PRNG_BOUNDED_INT_ASSERT_SVH
`define SMALL_PRNG_BOUNDED_INT_ASSERT_SVH

`ifndef SYNTHESIS
// Consequence must hold in the same cycle as the trigger.
`define SPRNG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// Consequence must hold in the cycle after the trigger.
`define SPRNG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define SPRNG_ASSERT_NOW(lbl, ante, cons)
`define SPRNG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/sprng_pkg.sv =====
// Types and constants shared across the small generator block.
package sprng_pkg;

  localparam int WORD_W     = 32;
  localparam int VALUE_W    = WORD_W + 1;
  localparam int WARMUP_W   = 5;
  localparam int DIV_CNT_W  = $clog2(WORD_W);

  localparam logic [WORD_W-1:0]   INIT_WORD_A    = 32'hf1ea5eed;
  localparam logic [WORD_W-1:0]   DEFAULT_SEED   = 32'hdeadbeef;
  localparam logic [WARMUP_W-1:0] WARMUP_DEFAULT = 5'd20;
  localparam int                  ROT_B          = 27;
  localparam int                  ROT_C          = 17;

  typedef logic [WORD_W-1:0]          word_t;
  typedef logic signed [VALUE_W-1:0]  value_t;

  typedef enum logic [1:0] {
    OP_RAW    = 2'd0,
    OP_RANGED = 2'd1,
    OP_RESEED = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BOUNDS  = 2'd1,
    ST_RESEEDED = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  // Control from the sequencer to the state-word unit.
  typedef struct packed {
    logic load;
    logic advance;
  } gen_ctrl_t;

  function automatic word_t rotl(input word_t v, input int k);
    rotl = (v << k) | (v >> (WORD_W - k));
  endfunction

endpackage

// ===== rtl/sprng_req_if.sv =====
// Request channel: opcode and inclusive range bounds.
interface sprng_req_if import sprng_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic signed [WORD_W-1:0]  range_low;
  logic signed [WORD_W-1:0]  range_high;

  modport source (output valid, opcode, range_low, range_high, input ready);
  modport sink   (input valid, opcode, range_low, range_high, output ready);
endinterface

// ===== rtl/sprng_rsp_if.sv =====
// Response channel: drawn value and status code.
interface sprng_rsp_if import sprng_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  value;
  logic [1:0]                 status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

// ===== rtl/sprng_gen.sv =====
// Four-word generator state with a single-round update unit.
module sprng_gen import sprng_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  gen_ctrl_t ctrl,
  input  word_t     seed,
  output word_t     round_word
);

  word_t word_a, word_b, word_c, word_d;
  word_t e_val, a_next;

  // One round: the new d is the output word
  always_comb begin
    e_val      = word_a - rotl(word_b, ROT_B);
    a_next     = word_b ^ rotl(word_c, ROT_C);
    round_word = e_val + a_next;
  end

  // Reset loads the default seed; the sequencer runs the warm-up
  always_ff @(posedge clk) begin
    if (rst) begin
      word_a <= INIT_WORD_A;
      word_b <= DEFAULT_SEED;
      word_c <= DEFAULT_SEED;
      word_d <= DEFAULT_SEED;
    end else if (ctrl.load) begin
      word_a <= INIT_WORD_A;
      word_b <= seed;
      word_c <= seed;
      word_d <= seed;
    end else if (ctrl.advance) begin
      word_a <= a_next;
      word_b <= word_c + word_d;
      word_c <= word_d + e_val;
      word_d <= round_word;
    end
  end

endmodule

// ===== rtl/sprng_remu.sv =====
// Restoring remainder unit, one quotient bit per cycle.
module sprng_remu import sprng_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  busy,
  output logic  done,
  output word_t rem
);

  logic [WORD_W:0]        part;
  logic [WORD_W:0]        part_sh;
  logic [WORD_W:0]        part_next;
  word_t                  quo;
  word_t                  dvs;
  logic [DIV_CNT_W-1:0]   cnt;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    part_sh = {part[WORD_W-1:0], quo[WORD_W-1]};
    if (part_sh >= {1'b0, dvs}) begin
      part_next = part_sh - {1'b0, dvs};
    end else begin
      part_next = part_sh;
    end
  end

  assign rem = part[WORD_W-1:0];

  // Sequence the bit steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      part <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      part <= part_next;
      quo  <= {quo[WORD_W-2:0], 1'b0};
    end
  end

endmodule

// ===== rtl/small_prng_bounded_int.sv =====
// Top level: request sequencer around the generator and the remainder unit.
//
// Channels: req (sink) carries opcode, range_low and range_high; rsp (source)
// carries value and status. Each accepted request yields exactly one response.
// cfg_we/cfg_wdata write the seed register used by the reseed opcode.
//
// Steps from the accepting edge to rsp.valid:
//   raw word: one round, then the result register.
//   bounds error or unused opcode: the result register only.
//   full 32-bit span: one round, then the result register.
//   ranged draw: the rejection threshold, one round for the try, the
//   reduction of the accepted word and the result register; each rejected
//   word adds another round. The bit-serial remainder unit computes both
//   the threshold and the reduction.
//   reseed: WARMUP_ROUNDS rounds, one a cycle, then the result register.
// One request is in flight at a time; req.ready is high only while idle.
// A finished response sits in the output register, so the next request is
// accepted while the receiver stalls; a second result then waits for the beat.
// Reset (synchronous, rst high) restores the default seed and runs the
// warm-up rounds; req.ready rises once they are done.
`include "small_prng_bounded_int_assert.svh"

module small_prng_bounded_int import sprng_pkg::*; #(
  parameter logic [WARMUP_W-1:0] WARMUP_ROUNDS = WARMUP_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  sprng_req_if.sink   req,
  sprng_rsp_if.source rsp,
  input  logic        cfg_we,
  input  word_t       cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WARM = 6'b000010,
    S_REM  = 6'b000100,
    S_DRAW = 6'b001000,
    S_MOD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    DRAW_RAW    = 2'd0,
    DRAW_FULL   = 2'd1,
    DRAW_RANGED = 2'd2,
    DRAW_NONE   = 2'd3
  } draw_kind_t;

  state_t                 state;
  draw_kind_t             kind;
  logic [WARMUP_W-1:0]    warm_cnt;
  logic                   report;
  word_t                  seed;
  word_t                  span;
  word_t                  limit;
  logic signed [WORD_W-1:0] lo;
  value_t                 res_value;
  status_t                res_status;

  gen_ctrl_t              gen_ctrl;
  word_t                  round_word;
  logic                   div_start;
  word_t                  div_dividend;
  word_t                  div_divisor;
  logic                   div_busy;
  logic                   div_done;
  word_t                  div_rem;

  logic                   accept;
  opcode_t                op;
  logic [VALUE_W-1:0]     span_full;
  logic                   bad_order;
  value_t                 lo_ext;
  value_t                 sum_in;
  value_t                 sum;

  assign accept    = req.valid && req.ready;
  assign op        = opcode_t'(req.opcode);
  assign req.ready = (state == S_IDLE);
  assign bad_order = (req.range_high < req.range_low);
  assign span_full = {req.range_high[WORD_W-1], req.range_high}
                   - {req.range_low[WORD_W-1], req.range_low} + VALUE_W'(1);

  // Shared adder: low bound plus the raw word or the reduced remainder
  assign lo_ext = {lo[WORD_W-1], lo};
  assign sum_in = (state == S_DRAW) ? value_t'({1'b0, round_word})
                                    : value_t'({1'b0, div_rem});
  assign sum    = lo_ext + sum_in;

  // Generator and divider control
  always_comb begin
    gen_ctrl.load    = accept && (op == OP_RESEED);
    gen_ctrl.advance = ((state == S_WARM) && (warm_cnt != '0)) || (state == S_DRAW);
    div_start        = (accept && (op == OP_RANGED) && !bad_order && !span_full[WORD_W])
                     || ((state == S_DRAW) && (kind == DRAW_RANGED)
                         && (round_word < limit));
    div_dividend     = (state == S_IDLE) ? '1 : round_word;
    div_divisor      = (state == S_IDLE) ? span_full[WORD_W-1:0] : span;
  end

  sprng_gen u_gen (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (gen_ctrl),
    .seed       (seed),
    .round_word (round_word)
  );

  sprng_remu u_remu (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= DEFAULT_SEED;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_WARM;
      warm_cnt <= WARMUP_ROUNDS;
      report   <= 1'b0;
      kind     <= DRAW_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_value  <= '0;
            res_status <= ST_OK;
            lo         <= req.range_low;
            span       <= span_full[WORD_W-1:0];
            unique case (op)
              OP_RAW: begin
                kind  <= DRAW_RAW;
                state <= S_DRAW;
              end
              OP_RANGED: begin
                priority if (bad_order) begin
                  res_status <= ST_BOUNDS;
                  state      <= S_OUT;
                end else if (span_full[WORD_W]) begin
                  kind  <= DRAW_FULL;
                  state <= S_DRAW;
                end else begin
                  kind  <= DRAW_RANGED;
                  state <= S_REM;
                end
              end
              OP_RESEED: begin
                warm_cnt <= WARMUP_ROUNDS;
                report   <= 1'b1;
                state    <= S_WARM;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_WARM: begin
          if (warm_cnt == '0) begin
            res_status <= ST_RESEEDED;
            res_value  <= '0;
            state      <= report ? S_OUT : S_IDLE;
            report     <= 1'b0;
          end else begin
            warm_cnt <= warm_cnt - 1'b1;
          end
        end
        S_REM: begin
          // Words at or above the threshold would bias the draw
          if (div_done) begin
            limit <= ~div_rem;
            state <= S_DRAW;
          end
        end
        S_DRAW: begin
          unique case (kind)
            DRAW_RAW: begin
              res_value <= value_t'({1'b0, round_word});
              state     <= S_OUT;
            end
            DRAW_FULL: begin
              res_value <= sum;
              state     <= S_OUT;
            end
            DRAW_RANGED: begin
              if (round_word < limit) begin
                state <= S_MOD;
              end
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_MOD: begin
          if (div_done) begin
            res_value <= sum;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load from the sequencer, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == S_OUT) && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!rsp.valid || rsp.ready)) begin
      rsp.value  <= res_value;
      rsp.status <= res_status;
    end
  end

  `SPRNG_ASSERT_NOW(a_idle_div_quiet, req.ready, !div_busy)
  `SPRNG_ASSERT_NOW(a_rem_below_span, div_done, div_rem < span)
  `SPRNG_ASSERT_NEXT(a_reseed_warms, accept && (op == OP_RESEED), state == S_WARM)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the bounded-range small generator: directed, seed, backpressure and random tests.
module tb import sprng_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [WORD_W-1:0] bound_t;

  typedef struct packed {
    value_t  value;
    status_t status;
  } draw_t;

  localparam bound_t      B_MIN          = 32'sh8000_0000;
  localparam bound_t      B_MAX          = 32'sh7fff_ffff;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TAIL_CYCLES    = 200;
  localparam int unsigned RANDOM_ITEMS   = 1900;
  localparam int unsigned RANDOM_PHASES  = 4;

  logic  clk;
  logic  rst;
  logic  cfg_we;
  word_t cfg_wdata;

  sprng_req_if req_ch ();
  sprng_rsp_if rsp_ch ();

  small_prng_bounded_int i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Generator words and seed as the block should hold them
  word_t gen_a, gen_b, gen_c, gen_d;
  word_t seed_copy;

  draw_t       expected_draws[$];
  int unsigned mismatch_count  = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned rsp_hold_cycles = 0;
  bit          idle_on         = 1'b1;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // One generator round; returns the new fourth word
  function automatic word_t gen_round();
    word_t e;
    e     = gen_a - {gen_b[4:0], gen_b[31:5]};
    gen_a = gen_b ^ {gen_c[14:0], gen_c[31:15]};
    gen_b = gen_c + gen_d;
    gen_c = gen_d + e;
    gen_d = e + gen_a;
    return gen_d;
  endfunction

  // Load the seed and run the discarded warm-up rounds
  function automatic void gen_reseed();
    word_t drop;
    gen_a = INIT_WORD_A;
    gen_b = seed_copy;
    gen_c = seed_copy;
    gen_d = seed_copy;
    for (int i = 0; i < int'(WARMUP_DEFAULT); i++) drop = gen_round();
  endfunction

  // Expected result of one request, advancing the generator as the block does
  function automatic draw_t predict_draw(opcode_t op, bound_t lo, bound_t hi);
    draw_t  r;
    longint span;
    longint limit;
    longint picked;
    word_t  x;
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      OP_RAW: r.value = {1'b0, gen_round()};
      OP_RANGED: begin
        if (hi < lo) begin
          r.status = ST_BOUNDS;
        end else begin
          span = longint'(hi) - longint'(lo) + 64'sd1;
          if (span == 64'sh1_0000_0000) begin
            // full span: one word, no rejection
            picked = longint'(lo) + longint'(gen_round());
          end else begin
            limit = 64'sh0_FFFF_FFFF - (64'sh0_FFFF_FFFF % span);
            do x = gen_round(); while (longint'(x) >= limit);
            picked = longint'(lo) + (longint'(x) % span);
          end
          r.value = picked[VALUE_W-1:0];
        end
      end
      OP_RESEED: begin
        gen_reseed();
        r.status = ST_RESEEDED;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random bounds: narrow, wide, unordered, near full and power-of-two spans
  function automatic void pick_bounds(output bound_t lo, output bound_t hi);
    longint top;
    bound_t tmp;
    int unsigned k;
    lo = $urandom;
    hi = $urandom;
    case ($urandom_range(0, 5))
      0, 1: begin
        top = longint'(lo) + longint'($urandom_range(0, 300));
        hi  = (top > longint'(B_MAX)) ? B_MAX : top[31:0];
      end
      2: begin
        if (hi < lo) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
      end
      3: ;
      4: begin
        lo = B_MIN + bound_t'($urandom_range(0, 3));
        hi = B_MAX - bound_t'($urandom_range(0, 3));
      end
      default: begin
        k   = $urandom_range(0, 31);
        top = longint'(lo) + (64'sd1 <<< k) - 64'sd1;
        if (top > longint'(B_MAX)) begin
          hi  = B_MAX;
          top = longint'(B_MAX) - (64'sd1 <<< k) + 64'sd1;
          lo  = top[31:0];
        end else begin
          hi = top[31:0];
        end
      end
    endcase
  endfunction

  // Offer one request beat and hold it until accepted
  task automatic send_item(opcode_t op, bound_t lo = '0, bound_t hi = '0);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.range_low  <= lo;
    req_ch.range_high <= hi;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic pause_until_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
  endtask

  task automatic write_seed(word_t v);
    pause_until_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    seed_copy = v;
  endtask

  task automatic test_directed();
    send_item(OP_RAW);
    send_item(OP_RAW);
    send_item(OP_RANGED, B_MIN, B_MAX);
    send_item(OP_RANGED, 32'sd5, -32'sd5);
    send_item(OP_RANGED, B_MAX, B_MIN);
    send_item(OP_RANGED, B_MIN, B_MIN);
    send_item(OP_RANGED, B_MAX, B_MAX);
    send_item(OP_RANGED, -32'sd3, 32'sd3);
    send_item(OP_RANGED, 32'sd0, B_MAX);
    send_item(OP_RANGED, B_MIN, 32'sd0);
    send_item(OP_RANGED, B_MAX - 32'sd2, B_MAX);
    send_item(OP_RANGED, B_MIN, B_MIN + 32'sd1);
    send_item(OP_RANGED, B_MIN + 32'sd1, B_MAX);
    send_item(OP_RANGED, -32'sd1, 32'sd0);
    send_item(OP_RESEED);
    send_item(OP_RAW);
    send_item(OP_UNUSED, B_MIN, B_MAX);
    send_item(OP_UNUSED, B_MAX, B_MIN);
  endtask

  // Reseed from each extreme, a random seed and the default seed, then draw a little
  task automatic test_seed_settings();
    word_t seeds[4];
    seeds[0] = '0;
    seeds[1] = '1;
    seeds[2] = $urandom;
    seeds[3] = DEFAULT_SEED;
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      send_item(OP_RESEED);
      send_item(OP_RAW);
      send_item(OP_RANGED, -32'sd10, 32'sd10);
    end
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    bound_t lo, hi;
    pause_until_drained();
    idle_on         = 1'b0;
    rsp_hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 8; i++) begin
      pick_bounds(lo, hi);
      if (i % 2 == 0) send_item(OP_RAW, lo, hi);
      else            send_item(OP_RANGED, lo, hi);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random(int unsigned n_items);
    bound_t      lo, hi;
    int unsigned pick;
    opcode_t     op;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1:       write_seed('0);
        2:       write_seed('1);
        default: write_seed($urandom);
      endcase
      for (int i = 0; i < n_items / RANDOM_PHASES; i++) begin
        // switch between idling and full-rate stretches now and then
        if (i % 64 == 0) idle_on = ($urandom_range(0, 2) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_RAW;
        else if (pick < 85) op = OP_RANGED;
        else if (pick < 92) op = OP_RESEED;
        else                op = OP_UNUSED;
        pick_bounds(lo, hi);
        send_item(op, lo, hi);
      end
    end
    idle_on = 1'b1;
  endtask

  // Receiver ready: random stall per beat, or one long hold when asked
  initial begin : rsp_ready_drive
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_cycles != 0) begin
        stall           = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  // Predict on every accepted request beat
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      expected_draws.push_back(predict_draw(opcode_t'(req_ch.opcode),
                                            req_ch.range_low, req_ch.range_high));
  end

  // Compare every result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    draw_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_draws.size() == 0) begin
        $error("result beat with nothing outstanding: value %0d status %0d",
               rsp_ch.value, rsp_ch.status);
        mismatch_count++;
      end else begin
        want = expected_draws.pop_front();
        if (rsp_ch.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, rsp_ch.value);
          mismatch_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatch_count++;
        end
      end
    end
  end

  // Abort if neither channel moves a beat for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.opcode     = OP_RAW;
    req_ch.range_low  = '0;
    req_ch.range_high = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst               = 1'b1;
    seed_copy         = DEFAULT_SEED;
    gen_reseed();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_seed_settings();
    test_backpressure();
    test_random(RANDOM_ITEMS);

    // drain, then give stray beats a chance to show up
    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
